### design/pgf_pkg.sv
// Shared widths, register codes and payload types of the pairwise gravity force block.
package pgf_pkg;

  localparam int CoordW    = 24;
  localparam int RadW      = 20;
  localparam int GainW     = 32;
  localparam int MarginW   = 24;
  localparam int RatioW    = 16;
  localparam int ForceW    = 32;
  localparam int DataW     = 32;
  localparam int AddrW     = 4;
  localparam int RegIdxW   = 2;

  localparam int RdistW    = 26;
  localparam int RdSqW     = 52;
  localparam int SqW       = 48;
  localparam int D2W       = 49;
  localparam int KW        = 52;
  localparam int KSplit    = 26;
  localparam int KrW       = 42;
  localparam int MW        = 68;
  localparam int PartW     = 23;
  localparam int ProdW     = 47;
  localparam int NumW      = 92;
  localparam int NumShift  = 16;
  localparam int SqrtW     = 41;
  localparam int SqrtRemW  = 82;
  localparam int SqrtShift = 32;
  localparam int DenLoW    = 21;
  localparam int DenLoPW   = 70;
  localparam int DenHiPW   = 69;
  localparam int DenW      = 90;
  localparam int RemW      = 108;
  localparam int QW        = 32;
  localparam int DivStages = QW + 1;

  localparam logic [RegIdxW-1:0] RegGain   = 2'd0;
  localparam logic [RegIdxW-1:0] RegMargin = 2'd1;
  localparam logic [RegIdxW-1:0] RegRatio  = 2'd2;

  localparam logic [GainW-1:0]   GainReset   = 32'h0001_0000;
  localparam logic [MarginW-1:0] MarginReset = 24'h00_0000;
  localparam logic [RatioW-1:0]  RatioReset  = 16'h0100;

  typedef struct packed {
    logic [GainW-1:0]   gain;
    logic [MarginW-1:0] margin;
    logic [RatioW-1:0]  ratio;
  } pgf_cfg_t;

  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic zero_x;
    logic zero_y;
    logic repel;
    logic coinc;
  } pgf_flags_t;

  typedef struct packed {
    logic [NumW-1:0] num_x;
    logic [NumW-1:0] num_y;
    logic [D2W-1:0]  d2;
    pgf_flags_t      flags;
  } pgf_side_t;

endpackage

### design/pgf_if.sv
// Valid/ready channel interfaces for the circle pair input and the force result.
interface pgf_in_if import pgf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CoordW-1:0] source_x;
  logic [CoordW-1:0] source_y;
  logic [CoordW-1:0] target_x;
  logic [CoordW-1:0] target_y;
  logic [RadW-1:0]   source_radius;
  logic [RadW-1:0]   target_radius;

  modport source (output valid, source_x, source_y, target_x, target_y, source_radius,
                  target_radius, input ready);
  modport sink (input valid, source_x, source_y, target_x, target_y, source_radius,
                target_radius, output ready);
endinterface

interface pgf_out_if import pgf_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [ForceW-1:0] force_x;
  logic signed [ForceW-1:0] force_y;
  logic                     repelling;
  logic                     coincident;
  logic                     overflowed;

  modport source (output valid, force_x, force_y, repelling, coincident, overflowed,
                  input ready);
  modport sink (input valid, force_x, force_y, repelling, coincident, overflowed,
                output ready);
endinterface

### design/pgf_front.sv
// Front pipeline: differences, squared distance, repulsion test and force numerators.
module pgf_front import pgf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  pgf_cfg_t  cfg_i,
  pgf_in_if.sink    in_i,
  output logic      valid_o,
  output pgf_side_t side_o
);

  logic              v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;

  logic              xneg1_d, yneg1_d;
  logic [CoordW-1:0] adx1_d, ady1_d;
  logic [RdistW-1:0] rdist1_d;
  logic [CoordW-1:0] adx1_q, ady1_q;
  logic              xneg1_q, yneg1_q;
  logic [RdistW-1:0] rdist1_q;
  logic [RadW-1:0]   rt1_q;

  logic [SqW-1:0]    sqx2_q, sqy2_q;
  logic [RdSqW-1:0]  rdsq2_q;
  logic [KW-1:0]     k2_q;
  logic [CoordW-1:0] adx2_q, ady2_q;
  logic              xneg2_q, yneg2_q;

  logic [D2W-1:0]    d2_3_d;
  logic [D2W-1:0]    d2_3_q;
  logic              repel3_q;
  logic [KrW-1:0]    krl3_q, krh3_q;
  logic [KW-1:0]     k3_q;
  logic [CoordW-1:0] adx3_q, ady3_q;
  logic              xneg3_q, yneg3_q;

  logic [MW-1:0]     m4_d;
  logic [MW-1:0]     m4_q;
  pgf_flags_t        flags4_d;
  pgf_flags_t        flags4_q;
  logic [D2W-1:0]    d2_4_q;
  logic [CoordW-1:0] adx4_q, ady4_q;

  logic [ProdW-1:0]  px5_q [3];
  logic [ProdW-1:0]  py5_q [3];
  logic [D2W-1:0]    d2_5_q;
  pgf_flags_t        flags5_q;

  pgf_side_t         side6_d;
  pgf_side_t         side6_q;

  assign in_i.ready = en_i;

  always_comb begin
    xneg1_d  = in_i.target_x < in_i.source_x;
    yneg1_d  = in_i.target_y < in_i.source_y;
    adx1_d   = xneg1_d ? in_i.source_x - in_i.target_x : in_i.target_x - in_i.source_x;
    ady1_d   = yneg1_d ? in_i.source_y - in_i.target_y : in_i.target_y - in_i.source_y;
    rdist1_d = (RdistW'(cfg_i.margin) << 1) + RdistW'(in_i.source_radius)
             + RdistW'(in_i.target_radius);
  end

  assign d2_3_d = D2W'(sqx2_q) + D2W'(sqy2_q);

  always_comb begin
    m4_d            = repel3_q ? (MW'(krh3_q) << KSplit) + MW'(krl3_q) : MW'(k3_q) << 8;
    flags4_d.neg_x  = xneg3_q ^ repel3_q;
    flags4_d.neg_y  = yneg3_q ^ repel3_q;
    flags4_d.zero_x = adx3_q == '0;
    flags4_d.zero_y = ady3_q == '0;
    flags4_d.repel  = repel3_q;
    flags4_d.coinc  = d2_3_q == '0;
  end

  always_comb begin
    side6_d.num_x = NumW'(px5_q[0]) + (NumW'(px5_q[1]) << PartW)
                  + (NumW'(px5_q[2]) << (2 * PartW));
    side6_d.num_y = NumW'(py5_q[0]) + (NumW'(py5_q[1]) << PartW)
                  + (NumW'(py5_q[2]) << (2 * PartW));
    side6_d.d2    = d2_5_q;
    side6_d.flags = flags5_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= in_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      adx1_q   <= adx1_d;
      ady1_q   <= ady1_d;
      xneg1_q  <= xneg1_d;
      yneg1_q  <= yneg1_d;
      rdist1_q <= rdist1_d;
      rt1_q    <= in_i.target_radius;

      sqx2_q   <= SqW'(adx1_q) * SqW'(adx1_q);
      sqy2_q   <= SqW'(ady1_q) * SqW'(ady1_q);
      rdsq2_q  <= RdSqW'(rdist1_q) * RdSqW'(rdist1_q);
      k2_q     <= KW'(cfg_i.gain) * KW'(rt1_q);
      adx2_q   <= adx1_q;
      ady2_q   <= ady1_q;
      xneg2_q  <= xneg1_q;
      yneg2_q  <= yneg1_q;

      d2_3_q   <= d2_3_d;
      repel3_q <= RdSqW'(d2_3_d) < rdsq2_q;
      krl3_q   <= KrW'(k2_q[KSplit-1:0]) * KrW'(cfg_i.ratio);
      krh3_q   <= KrW'(k2_q[KW-1:KSplit]) * KrW'(cfg_i.ratio);
      k3_q     <= k2_q;
      adx3_q   <= adx2_q;
      ady3_q   <= ady2_q;
      xneg3_q  <= xneg2_q;
      yneg3_q  <= yneg2_q;

      m4_q     <= m4_d;
      flags4_q <= flags4_d;
      d2_4_q   <= d2_3_q;
      adx4_q   <= adx3_q;
      ady4_q   <= ady3_q;

      px5_q[0] <= ProdW'(m4_q[PartW-1:0]) * ProdW'(adx4_q);
      px5_q[1] <= ProdW'(m4_q[2*PartW-1:PartW]) * ProdW'(adx4_q);
      px5_q[2] <= ProdW'(m4_q[MW-1:2*PartW]) * ProdW'(adx4_q);
      py5_q[0] <= ProdW'(m4_q[PartW-1:0]) * ProdW'(ady4_q);
      py5_q[1] <= ProdW'(m4_q[2*PartW-1:PartW]) * ProdW'(ady4_q);
      py5_q[2] <= ProdW'(m4_q[MW-1:2*PartW]) * ProdW'(ady4_q);
      d2_5_q   <= d2_4_q;
      flags5_q <= flags4_q;

      side6_q  <= side6_d;
    end
  end

  assign valid_o = v6_q;
  assign side_o  = side6_q;

endmodule

### design/pgf_sqrt.sv
// Pipelined integer square root of the scaled squared distance, one root bit per stage.
module pgf_sqrt import pgf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  pgf_side_t        side_i,
  output logic             valid_o,
  output logic [SqrtW-1:0] root_o,
  output pgf_side_t        side_o
);

  logic                v_q    [SqrtW];
  logic [SqrtRemW-1:0] rem_q  [SqrtW];
  logic [SqrtW-1:0]    root_q [SqrtW];
  pgf_side_t           side_q [SqrtW];

  for (genvar s = 0; s < SqrtW; s++) begin : g_stage
    localparam int Bit = SqrtW - 1 - s;

    logic                v_in;
    logic [SqrtRemW-1:0] rem_in, trial, rem_d;
    logic [SqrtW-1:0]    root_in, root_d;
    pgf_side_t           side_in;

    if (s == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = SqrtRemW'(side_i.d2) << SqrtShift;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign side_in = side_q[s-1];
    end

    assign trial = (SqrtRemW'(root_in) << (Bit + 1)) | (SqrtRemW'(1) << (2 * Bit));

    always_comb begin
      rem_d  = rem_in;
      root_d = root_in;
      if (rem_in >= trial) begin
        rem_d  = rem_in - trial;
        root_d = root_in | (SqrtW'(1) << Bit);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= rem_d;
        root_q[s] <= root_d;
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o = v_q[SqrtW-1];
  assign root_o  = root_q[SqrtW-1];
  assign side_o  = side_q[SqrtW-1];

endmodule

### design/pgf_div.sv
// Divisor product and two-lane pipelined restoring divider: an overflow check stage, then one quotient bit per stage.
module pgf_div import pgf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [SqrtW-1:0] root_i,
  input  pgf_side_t        side_i,
  output logic             valid_o,
  output logic [QW-1:0]    quot_x_o,
  output logic [QW-1:0]    quot_y_o,
  output logic             big_x_o,
  output logic             big_y_o,
  output pgf_flags_t       flags_o
);

  logic               v1_q, v2_q;
  logic [DenLoPW-1:0] plo1_q;
  logic [DenHiPW-1:0] phi1_q;
  logic [NumW-1:0]    numx1_q, numy1_q;
  pgf_flags_t         flags1_q;
  logic [DenW-1:0]    den2_q;
  logic [RemW-1:0]    remx2_q, remy2_q;
  pgf_flags_t         flags2_q;

  logic               v_q     [DivStages];
  logic [DenW-1:0]    den_q   [DivStages];
  logic [RemW-1:0]    remx_q  [DivStages];
  logic [RemW-1:0]    remy_q  [DivStages];
  logic [QW-1:0]      qx_q    [DivStages];
  logic [QW-1:0]      qy_q    [DivStages];
  logic               bigx_q  [DivStages];
  logic               bigy_q  [DivStages];
  pgf_flags_t         flags_q [DivStages];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      plo1_q   <= DenLoPW'(side_i.d2) * DenLoPW'(root_i[DenLoW-1:0]);
      phi1_q   <= DenHiPW'(side_i.d2) * DenHiPW'(root_i[SqrtW-1:DenLoW]);
      numx1_q  <= side_i.num_x;
      numy1_q  <= side_i.num_y;
      flags1_q <= side_i.flags;

      den2_q   <= DenW'(plo1_q) + (DenW'(phi1_q) << DenLoW);
      remx2_q  <= RemW'(numx1_q) << NumShift;
      remy2_q  <= RemW'(numy1_q) << NumShift;
      flags2_q <= flags1_q;
    end
  end

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    localparam int Bit = QW - s;

    logic            v_in, bigx_in, bigy_in, bigx_d, bigy_d;
    logic [DenW-1:0] den_in;
    logic [RemW-1:0] remx_in, remy_in, remx_d, remy_d;
    logic [QW-1:0]   qx_in, qy_in, qx_d, qy_d;
    pgf_flags_t      flags_in;

    if (s == 0) begin : g_first
      assign v_in     = v2_q;
      assign den_in   = den2_q;
      assign remx_in  = remx2_q;
      assign remy_in  = remy2_q;
      assign qx_in    = '0;
      assign qy_in    = '0;
      assign bigx_in  = 1'b0;
      assign bigy_in  = 1'b0;
      assign flags_in = flags2_q;

      always_comb begin
        remx_d = remx_in;
        remy_d = remy_in;
        qx_d   = qx_in;
        qy_d   = qy_in;
        bigx_d = bigx_in || ((remx_in >> Bit) >= RemW'(den_in));
        bigy_d = bigy_in || ((remy_in >> Bit) >= RemW'(den_in));
      end
    end else begin : g_next
      logic [RemW-1:0] sub;

      assign v_in     = v_q[s-1];
      assign den_in   = den_q[s-1];
      assign remx_in  = remx_q[s-1];
      assign remy_in  = remy_q[s-1];
      assign qx_in    = qx_q[s-1];
      assign qy_in    = qy_q[s-1];
      assign bigx_in  = bigx_q[s-1];
      assign bigy_in  = bigy_q[s-1];
      assign flags_in = flags_q[s-1];
      assign sub      = RemW'(den_in) << Bit;

      always_comb begin
        remx_d = remx_in;
        remy_d = remy_in;
        qx_d   = qx_in;
        qy_d   = qy_in;
        bigx_d = bigx_in;
        bigy_d = bigy_in;
        if ((remx_in >> Bit) >= RemW'(den_in)) begin
          remx_d = remx_in - sub;
          qx_d   = qx_in | (QW'(1) << Bit);
        end
        if ((remy_in >> Bit) >= RemW'(den_in)) begin
          remy_d = remy_in - sub;
          qy_d   = qy_in | (QW'(1) << Bit);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[s]   <= den_in;
        remx_q[s]  <= remx_d;
        remy_q[s]  <= remy_d;
        qx_q[s]    <= qx_d;
        qy_q[s]    <= qy_d;
        bigx_q[s]  <= bigx_d;
        bigy_q[s]  <= bigy_d;
        flags_q[s] <= flags_in;
      end
    end
  end

  assign valid_o  = v_q[DivStages-1];
  assign quot_x_o = qx_q[DivStages-1];
  assign quot_y_o = qy_q[DivStages-1];
  assign big_x_o  = bigx_q[DivStages-1];
  assign big_y_o  = bigy_q[DivStages-1];
  assign flags_o  = flags_q[DivStages-1];

endmodule

### design/pairwise_gravity_force_top.sv
// Top level of the pairwise gravity force block: registers, pipeline and result stage.
// An input transfer passes 6 front stages, 41 root stages, 35 divider stages and the
// output register on the way to its result.
// Throughput is one pair per cycle; the whole pipeline holds only while a result waits.
// Reset clears all valid bits and loads the register defaults; no clearing pass is needed.
module pairwise_gravity_force_top import pgf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  pgf_in_if.sink           in_i,
  pgf_out_if.source        out_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  pgf_cfg_t          cfg_q;
  logic [RegIdxW-1:0] reg_idx;
  logic              en;

  logic              front_valid, sqrt_valid, div_valid;
  pgf_side_t         front_side, sqrt_side;
  logic [SqrtW-1:0]  root;
  logic [QW-1:0]     quot_x, quot_y;
  logic              big_x, big_y;
  pgf_flags_t        div_flags;

  logic [ForceW:0]   sat_x, sat_y;
  logic              out_valid_q;
  logic [ForceW-1:0] force_x_q, force_y_q;
  logic              repel_q, coinc_q, ovf_q;

  function automatic logic [ForceW:0] saturate(logic [QW-1:0] q, logic big, logic neg,
                                                logic skip);
    logic [ForceW-1:0] limit;
    logic [ForceW-1:0] mag;
    logic              ovf;
    limit = neg ? (ForceW'(1) << (ForceW - 1)) : ((ForceW'(1) << (ForceW - 1)) - 1'b1);
    ovf   = 1'b0;
    mag   = ForceW'(q);
    if (skip) begin
      mag = '0;
    end else if (big || (ForceW'(q) > limit)) begin
      mag = limit;
      ovf = 1'b1;
    end
    return {ovf, neg ? ForceW'(-mag) : mag};
  endfunction

  assign reg_idx = paddr[AddrW-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain   <= GainReset;
      cfg_q.margin <= MarginReset;
      cfg_q.ratio  <= RatioReset;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        RegGain:   cfg_q.gain   <= pwdata[GainW-1:0];
        RegMargin: cfg_q.margin <= pwdata[MarginW-1:0];
        RegRatio:  cfg_q.ratio  <= pwdata[RatioW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegGain:   prdata = DataW'(cfg_q.gain);
      RegMargin: prdata = DataW'(cfg_q.margin);
      RegRatio:  prdata = DataW'(cfg_q.ratio);
      default:   prdata = '0;
    endcase
  end

  assign en = !out_valid_q || out_o.ready;

  pgf_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cfg_i   (cfg_q),
    .in_i    (in_i),
    .valid_o (front_valid),
    .side_o  (front_side)
  );

  pgf_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (front_valid),
    .side_i  (front_side),
    .valid_o (sqrt_valid),
    .root_o  (root),
    .side_o  (sqrt_side)
  );

  pgf_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (sqrt_valid),
    .root_i   (root),
    .side_i   (sqrt_side),
    .valid_o  (div_valid),
    .quot_x_o (quot_x),
    .quot_y_o (quot_y),
    .big_x_o  (big_x),
    .big_y_o  (big_y),
    .flags_o  (div_flags)
  );

  assign sat_x = saturate(quot_x, big_x, div_flags.neg_x, div_flags.coinc || div_flags.zero_x);
  assign sat_y = saturate(quot_y, big_y, div_flags.neg_y, div_flags.coinc || div_flags.zero_y);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      force_x_q <= sat_x[ForceW-1:0];
      force_y_q <= sat_y[ForceW-1:0];
      repel_q   <= div_flags.repel;
      coinc_q   <= div_flags.coinc;
      ovf_q     <= sat_x[ForceW] || sat_y[ForceW];
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.force_x    = force_x_q;
  assign out_o.force_y    = force_y_q;
  assign out_o.repelling  = repel_q;
  assign out_o.coincident = coinc_q;
  assign out_o.overflowed = ovf_q;

  a_coinc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.coincident |->
      out_o.force_x == '0 && out_o.force_y == '0 && !out_o.overflowed)
    else $error("coincident result carries a force");

  a_ovf_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.overflowed |->
      out_o.force_x == 32'sh7fff_ffff || out_o.force_x == 32'sh8000_0000 ||
      out_o.force_y == 32'sh7fff_ffff || out_o.force_y == 32'sh8000_0000)
    else $error("overflow flag without a clamped component");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(force_x_q) && $stable(force_y_q) && $stable(div_valid))
    else $error("pipeline moved while the result transfer was stalled");

endmodule
